FILE: src/sps_pkg.sv
// Package for the sensor poll sequencer: payload types, phase, action and register codes.
package sps_pkg;

  // Largest sensor count that the bus report is taken at.
  localparam logic [3:0] MAX_SENSORS = 4'd8;

  // Sequencer phases.
  localparam logic [1:0] PH_INIT    = 2'd0;
  localparam logic [1:0] PH_REQUEST = 2'd1;
  localparam logic [1:0] PH_READ    = 2'd2;

  // Action codes of a result.
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_REINIT  = 2'd1;
  localparam logic [1:0] ACT_REQUEST = 2'd2;
  localparam logic [1:0] ACT_READ    = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_PERIOD      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_PERIOD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_READ_PERIOD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_SENSORS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT      = 3'd4;

  // Failed round counter saturation value.
  localparam logic [7:0] FAIL_MAX = 8'd255;

  // One tick of input.
  typedef struct packed {
    logic [31:0]        timestamp;
    logic [3:0]         bus_sensor_count;
    logic               read_ok;
    logic signed [15:0] raw_temp;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [1:0]         action;
    logic [2:0]         sensor_index;
    logic               read_failed;
    logic signed [15:0] temperature;
    logic               count_report_valid;
    logic [3:0]         reported_count;
  } out_item_t;

endpackage

FILE: src/sps_in_if.sv
// Input channel interface for the sensor poll sequencer.
interface sps_in_if;
  import sps_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/sps_out_if.sv
// Result channel interface for the sensor poll sequencer.
interface sps_out_if;
  import sps_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/sensor_poll_sequencer_unit.sv
// Top level of the sensor poll sequencer: tick handling, phase state and result register.
//
//   Channel  | Direction | Handshake        | Payload
//   ---------+-----------+------------------+---------------------------------------------
//   in_if    | sink      | valid / ready    | timestamp, bus_sensor_count, read_ok, raw_temp
//   out_if   | source    | valid / ready    | action, sensor_index, read_failed, temperature,
//            |           |                  | count_report_valid, reported_count
//   cfg_*    | write     | cfg_we           | cfg_idx, cfg_wdata
//
// Every accepted tick yields exactly one result, which appears in the result register in the next cycle.
// One tick is accepted per cycle while out_if does not stall; the rate is set by the single result register.
// A new tick is taken whenever the result register is empty or is drained in the same cycle.
// A stall on out_if holds the result and stops intake until the result is taken.
// Reset (rst_n low, synchronous) loads the default periods and limits and empties the result.
module sensor_poll_sequencer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sps_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [31:0]                     cfg_wdata,
  sps_in_if.sink                          in_if,
  sps_out_if.source                       out_if
);
  import sps_pkg::*;

  // Configuration registers.
  logic [31:0] init_period_r;
  logic [31:0] request_period_r;
  logic [31:0] read_period_r;
  logic [3:0]  expected_sensors_r;
  logic [7:0]  error_limit_r;

  // Sequencer state.
  logic [1:0]  phase_r,         phase_nxt;
  logic        time_pending_r,  time_pending_nxt;
  logic [31:0] start_time_r,    start_time_nxt;
  logic [3:0]  known_count_r,   known_count_nxt;
  logic [3:0]  next_sensor_r,   next_sensor_nxt;
  logic        round_error_r,   round_error_nxt;
  logic [7:0]  failed_rounds_r, failed_rounds_nxt;

  // Result register.
  logic        out_valid_r;
  out_item_t   out_data_r;
  out_item_t   res_nxt;

  logic        in_fire;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_period_r      <= 32'd1000;
      request_period_r   <= 32'd750;
      read_period_r      <= 32'd10;
      expected_sensors_r <= 4'd1;
      error_limit_r      <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_INIT_PERIOD:      init_period_r      <= cfg_wdata;
        REG_REQUEST_PERIOD:   request_period_r   <= cfg_wdata;
        REG_READ_PERIOD:      read_period_r      <= cfg_wdata;
        REG_EXPECTED_SENSORS: expected_sensors_r <= cfg_wdata[3:0];
        REG_ERROR_LIMIT:      error_limit_r      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Next state and result for the tick at the input.
  always_comb begin
    logic [31:0] period;
    logic [31:0] elapsed;
    logic [3:0]  cnt;
    logic [7:0]  fails;
    logic        go_init;
    logic        go_request;

    phase_nxt         = phase_r;
    time_pending_nxt  = time_pending_r;
    start_time_nxt    = start_time_r;
    known_count_nxt   = known_count_r;
    next_sensor_nxt   = next_sensor_r;
    round_error_nxt   = round_error_r;
    failed_rounds_nxt = failed_rounds_r;
    res_nxt           = '0;
    go_init           = 1'b0;
    go_request        = 1'b0;
    fails             = failed_rounds_r;

    // Period of the current phase; an unused phase is timed like wait init.
    unique case (phase_r)
      PH_REQUEST: period = request_period_r;
      PH_READ:    period = read_period_r;
      default:    period = init_period_r;
    endcase

    elapsed = in_if.data.timestamp - start_time_r;

    // Saturate the bus count.
    cnt = (in_if.data.bus_sensor_count > MAX_SENSORS) ? MAX_SENSORS
                                                      : in_if.data.bus_sensor_count;

    if (time_pending_r) begin
      // First tick after a state change only latches the time.
      start_time_nxt   = in_if.data.timestamp;
      time_pending_nxt = 1'b0;
    end else if (elapsed >= period) begin
      unique case (phase_r)
        PH_REQUEST: begin
          phase_nxt        = PH_READ;
          time_pending_nxt = 1'b1;
        end
        PH_READ: begin
          if (next_sensor_r < known_count_r) begin
            // Read one sensor.
            res_nxt.action       = ACT_READ;
            res_nxt.sensor_index = next_sensor_r[2:0];
            if (in_if.data.read_ok) begin
              res_nxt.temperature = in_if.data.raw_temp;
            end else begin
              res_nxt.read_failed = 1'b1;
              round_error_nxt     = 1'b1;
            end
            next_sensor_nxt  = next_sensor_r + 4'd1;
            time_pending_nxt = 1'b1;
          end else begin
            // End of round: update the failed round count.
            if (failed_rounds_r < FAIL_MAX) begin
              fails = failed_rounds_r + 8'd1;
            end
            if (known_count_r >= expected_sensors_r && !round_error_r) begin
              fails = 8'd0;
            end
            failed_rounds_nxt = fails;
            if (fails < error_limit_r) begin
              go_request = 1'b1;
            end else begin
              go_init = 1'b1;
            end
          end
        end
        PH_INIT: begin
          if (cnt != 4'd0) begin
            if (cnt != known_count_r) begin
              known_count_nxt            = cnt;
              res_nxt.count_report_valid = 1'b1;
              res_nxt.reported_count     = cnt;
            end
            go_request = 1'b1;
          end else begin
            go_init = 1'b1;
          end
        end
        default: go_init = 1'b1;
      endcase
    end

    // Start a conversion round.
    if (go_request) begin
      next_sensor_nxt  = 4'd0;
      round_error_nxt  = 1'b0;
      res_nxt.action   = ACT_REQUEST;
      phase_nxt        = PH_REQUEST;
      time_pending_nxt = 1'b1;
    end

    // Re-init the bus; the count report is always zero.
    if (go_init) begin
      known_count_nxt            = 4'd0;
      failed_rounds_nxt          = 8'd0;
      res_nxt.action             = ACT_REINIT;
      res_nxt.count_report_valid = 1'b1;
      res_nxt.reported_count     = 4'd0;
      phase_nxt                  = PH_INIT;
      time_pending_nxt           = 1'b1;
    end
  end

  // State update on an accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_INIT;
      time_pending_r  <= 1'b1;
      start_time_r    <= 32'd0;
      known_count_r   <= 4'd0;
      next_sensor_r   <= 4'd0;
      round_error_r   <= 1'b0;
      failed_rounds_r <= 8'd0;
    end else if (in_fire) begin
      phase_r         <= phase_nxt;
      time_pending_r  <= time_pending_nxt;
      start_time_r    <= start_time_nxt;
      known_count_r   <= known_count_nxt;
      next_sensor_r   <= next_sensor_nxt;
      round_error_r   <= round_error_nxt;
      failed_rounds_r <= failed_rounds_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res_nxt;
    end
  end

endmodule
